### src/fcl_pkg.sv
package fcl_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_RESERVED_SECTORS     = 3'd0;
	localparam logic [2:0] REG_SECTORS_PER_FAT      = 3'd1;
	localparam logic [2:0] REG_FAT_COPIES           = 3'd2;
	localparam logic [2:0] REG_ROOT_ENTRIES         = 3'd3;
	localparam logic [2:0] REG_TOTAL_SECTORS        = 3'd4;
	localparam logic [2:0] REG_SECTOR_SIZE_LOG2     = 3'd5;
	localparam logic [2:0] REG_CLUSTER_SECTORS_LOG2 = 3'd6;

	typedef enum logic [1:0] {
		KIND_FAT12 = 2'd0,
		KIND_FAT16 = 2'd1,
		KIND_FAT32 = 2'd2
	} fat_kind_t;

	// Cluster count thresholds between table types
	localparam logic [31:0] FAT12_COUNT_LIMIT = 32'd4085;
	localparam logic [31:0] FAT16_COUNT_LIMIT = 32'd65525;

	// First reserved / end-of-chain values per table type
	localparam logic [11:0] FAT12_BAD  = 12'hFF7;
	localparam logic [15:0] FAT16_BAD  = 16'hFFF7;
	localparam logic [31:0] FAT32_MASK = 32'h0FFF_FFFF;
	localparam logic [27:0] FAT32_BAD  = 28'hFFF_FFF7;

	localparam logic [3:0] SECTOR_LOG2_MIN = 4'd9;
	localparam logic [3:0] SECTOR_LOG2_MAX = 4'd12;

	localparam logic [15:0] RESET_RESERVED     = 16'd1;
	localparam logic [2:0]  RESET_FAT_COPIES   = 3'd2;
	localparam logic [15:0] RESET_ROOT_ENTRIES = 16'd512;
	localparam logic [3:0]  RESET_SECTOR_LOG2  = 4'd9;

	// Clamp bytes-per-sector exponent to the supported range
	function automatic logic [3:0] eff_sector_log2(input logic [3:0] raw);
		logic [3:0] res;
		if (raw < SECTOR_LOG2_MIN) begin
			res = SECTOR_LOG2_MIN;
		end else if (raw > SECTOR_LOG2_MAX) begin
			res = SECTOR_LOG2_MAX;
		end else begin
			res = raw;
		end
		return res;
	endfunction

endpackage

### src/fat_cluster_chain_locator.sv
// FAT cluster chain locator.
// Request channel (req_valid/req_ready) takes a cluster number and the 32-bit
// little-endian word the host read at that cluster's table entry. Response
// channel (rsp_valid/rsp_ready) returns the table type, the table sector and
// byte offset of the entry, the decoded next cluster (0 for end of chain or
// bad) and the first data sector of the cluster.
// Geometry is loaded through cfg_we/cfg_index/cfg_data, one register per
// write, only while no request is in flight; the user must keep to this,
// the block itself does not enforce it. rsp_valid rises once a word has
// passed the four-stage pipeline (geometry multiply, table base add,
// cluster count and type, final select), which takes one word per cycle
// while the response channel is not stalled.
// Each stage has its own valid bit and ready: a stalled response stage holds
// its word while empty stages upstream keep filling, so no word is dropped or
// duplicated. req_ready falls only once every stage holds a word.
// Reset clears all valid bits and loads the default geometry (one reserved
// sector, two tables, 512 root entries, 512-byte sectors).
module fat_cluster_chain_locator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [27:0] cluster,
	input  logic [31:0] entry_word,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  fat_kind,
	output logic [31:0] table_sector,
	output logic [11:0] byte_offset,
	output logic [27:0] next_link,
	output logic [31:0] data_start
);

	// Geometry registers
	logic [15:0] reserved_sectors_q;
	logic [31:0] sectors_per_fat_q;
	logic [2:0]  fat_copies_q;
	logic [15:0] root_entries_q;
	logic [31:0] total_sectors_q;
	logic [3:0]  sector_size_log2_q;
	logic [2:0]  cluster_sectors_log2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_sectors_q     <= fcl_pkg::RESET_RESERVED;
			sectors_per_fat_q      <= '0;
			fat_copies_q           <= fcl_pkg::RESET_FAT_COPIES;
			root_entries_q         <= fcl_pkg::RESET_ROOT_ENTRIES;
			total_sectors_q        <= '0;
			sector_size_log2_q     <= fcl_pkg::RESET_SECTOR_LOG2;
			cluster_sectors_log2_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fcl_pkg::REG_RESERVED_SECTORS:     reserved_sectors_q     <= cfg_data[15:0];
				fcl_pkg::REG_SECTORS_PER_FAT:      sectors_per_fat_q      <= cfg_data;
				fcl_pkg::REG_FAT_COPIES:           fat_copies_q           <= cfg_data[2:0];
				fcl_pkg::REG_ROOT_ENTRIES:         root_entries_q         <= cfg_data[15:0];
				fcl_pkg::REG_TOTAL_SECTORS:        total_sectors_q        <= cfg_data;
				fcl_pkg::REG_SECTOR_SIZE_LOG2:     sector_size_log2_q     <= cfg_data[3:0];
				fcl_pkg::REG_CLUSTER_SECTORS_LOG2: cluster_sectors_log2_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	logic [3:0]  slog;
	logic [12:0] bps_m1;
	assign slog   = fcl_pkg::eff_sector_log2(sector_size_log2_q);
	assign bps_m1 = (13'd1 << slog) - 13'd1;

	// Stage handshake: each stage loads when empty or when its successor moves
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	assign rdy4      = !v_s4 || rsp_ready;
	assign rdy3      = !v_s3 || rdy4;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign req_ready = rdy1;
	assign rsp_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= req_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Stage 1: root directory sectors and table area size
	logic [21:0] rds_sum;
	logic [21:0] rds_shift;
	logic [34:0] fat_area;
	assign rds_sum   = {1'b0, root_entries_q, 5'b0} + {9'b0, bps_m1};
	assign rds_shift = rds_sum >> slog;
	assign fat_area  = sectors_per_fat_q * fat_copies_q;

	logic [27:0] cl_s1;
	logic [31:0] word_s1;
	logic [12:0] rds_s1;
	logic [31:0] fat_area_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && req_valid) begin
			cl_s1       <= cluster;
			word_s1     <= entry_word;
			rds_s1      <= rds_shift[12:0];
			fat_area_s1 <= fat_area[31:0];
		end
	end

	// Stage 2: first data sector, FAT12 offset, per-type entry decode
	logic [11:0] raw12;
	logic [11:0] dec12;
	logic [15:0] dec16;
	logic [31:0] masked32;
	logic [27:0] dec32;
	assign raw12    = cl_s1[0] ? word_s1[15:4] : word_s1[11:0];
	assign dec12    = (raw12 >= fcl_pkg::FAT12_BAD) ? 12'd0 : raw12;
	assign dec16    = (word_s1[15:0] >= fcl_pkg::FAT16_BAD) ? 16'd0 : word_s1[15:0];
	assign masked32 = word_s1 & fcl_pkg::FAT32_MASK;
	assign dec32    = (masked32[27:0] >= fcl_pkg::FAT32_BAD) ? 28'd0 : masked32[27:0];

	logic [27:0] cl_s2;
	logic [12:0] rds_s2;
	logic [31:0] first_s2;
	logic [28:0] off12_s2;
	logic [11:0] n12_s2;
	logic [15:0] n16_s2;
	logic [27:0] n32_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			cl_s2    <= cl_s1;
			rds_s2   <= rds_s1;
			first_s2 <= {16'b0, reserved_sectors_q} + fat_area_s1;
			off12_s2 <= {1'b0, cl_s1} + {2'b0, cl_s1[27:1]};
			n12_s2   <= dec12;
			n16_s2   <= dec16;
			n32_s2   <= dec32;
		end
	end

	// Stage 3: cluster count, table type, data sector base
	logic [31:0] data_secs;
	logic [31:0] clus_count;
	logic [31:0] cl_m2;
	logic [31:0] cl_scaled;
	fcl_pkg::fat_kind_t kind_next;
	assign data_secs  = total_sectors_q - first_s2 - {19'b0, rds_s2};
	assign clus_count = data_secs >> cluster_sectors_log2_q;
	assign cl_m2      = {4'b0, cl_s2} - 32'd2;
	assign cl_scaled  = cl_m2 << cluster_sectors_log2_q;

	always_comb begin
		priority if (clus_count < fcl_pkg::FAT12_COUNT_LIMIT) begin
			kind_next = fcl_pkg::KIND_FAT12;
		end else if (clus_count < fcl_pkg::FAT16_COUNT_LIMIT) begin
			kind_next = fcl_pkg::KIND_FAT16;
		end else begin
			kind_next = fcl_pkg::KIND_FAT32;
		end
	end

	logic [27:0] cl_s3;
	logic [12:0] rds_s3;
	logic [28:0] off12_s3;
	logic [11:0] n12_s3;
	logic [15:0] n16_s3;
	logic [27:0] n32_s3;
	logic [31:0] start_s3;
	fcl_pkg::fat_kind_t kind_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			cl_s3    <= cl_s2;
			rds_s3   <= rds_s2;
			off12_s3 <= off12_s2;
			n12_s3   <= n12_s2;
			n16_s3   <= n16_s2;
			n32_s3   <= n32_s2;
			start_s3 <= cl_scaled + first_s2;
			kind_s3  <= kind_next;
		end
	end

	// Stage 4: select by type, locate entry, add root directory offset
	logic [29:0] off_sel;
	logic [27:0] next_sel;
	logic [29:0] off_sect;
	logic        add_root;

	always_comb begin
		unique case (kind_s3)
			fcl_pkg::KIND_FAT12: begin
				off_sel  = {1'b0, off12_s3};
				next_sel = {16'b0, n12_s3};
			end
			fcl_pkg::KIND_FAT16: begin
				off_sel  = {1'b0, cl_s3, 1'b0};
				next_sel = {12'b0, n16_s3};
			end
			fcl_pkg::KIND_FAT32: begin
				off_sel  = {cl_s3, 2'b0};
				next_sel = n32_s3;
			end
			default: begin
				off_sel  = {cl_s3, 2'b0};
				next_sel = n32_s3;
			end
		endcase
	end

	assign off_sect = off_sel >> slog;
	// Cluster 2 is the root directory marker on FAT12/16: no root offset
	assign add_root = (cl_s3 > 28'd2) && (kind_s3 != fcl_pkg::KIND_FAT32);

	fcl_pkg::fat_kind_t kind_s4;
	logic [31:0] table_s4;
	logic [11:0] boff_s4;
	logic [27:0] next_s4;
	logic [31:0] start_s4;

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			kind_s4  <= kind_s3;
			table_s4 <= {16'b0, reserved_sectors_q} + {2'b0, off_sect};
			boff_s4  <= off_sel[11:0] & bps_m1[11:0];
			next_s4  <= next_sel;
			start_s4 <= add_root ? (start_s3 + {19'b0, rds_s3}) : start_s3;
		end
	end

	assign fat_kind     = kind_s4;
	assign table_sector = table_s4;
	assign byte_offset  = boff_s4;
	assign next_link    = next_s4;
	assign data_start   = start_s4;

	// Accepted request must occupy the first stage
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> v_s1)
		else $error("accepted request did not enter stage 1");

	// Decoded FAT12 link never carries a reserved value
	a_fat12_link: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (fat_kind == fcl_pkg::KIND_FAT12) |-> (next_link < 28'hFF7))
		else $error("FAT12 next link out of range");

	// FAT12/16 links fit in 16 bits
	a_narrow_link: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (fat_kind != fcl_pkg::KIND_FAT32) |-> (next_link[27:16] == 12'd0))
		else $error("FAT12/16 next link wider than 16 bits");

	// Byte offset stays inside one sector
	a_offset_in_sector: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((byte_offset & ~bps_m1[11:0]) == 12'd0))
		else $error("byte offset beyond sector size");

endmodule

### bench/tb_fat_cluster_chain_locator.sv
module tb_fat_cluster_chain_locator;
	timeunit 1ns;
	timeprecision 1ps;

	// index past the last register: the write must be ignored
	localparam logic [2:0] REG_NONE = 3'd7;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned REPORT_LIMIT = 40;

	typedef struct {
		logic [27:0] cl;
		logic [31:0] word;
	} lookup_t;

	typedef struct {
		fcl_pkg::fat_kind_t kind;
		logic [31:0] sector;
		logic [11:0] offset;
		logic [27:0] next;
		logic [31:0] start;
	} location_t;

	typedef struct {
		logic [3:0]  slog;
		logic [31:0] root_secs;
		logic [31:0] data_base;
		logic [31:0] clusters;
	} volume_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic [27:0] cluster = '0;
	logic [31:0] entry_word = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	logic [1:0]  fat_kind;
	logic [31:0] table_sector;
	logic [11:0] byte_offset;
	logic [27:0] next_link;
	logic [31:0] data_start;

	// shadow copy of the geometry registers
	logic [15:0] vol_reserved = fcl_pkg::RESET_RESERVED;
	logic [31:0] vol_spf = '0;
	logic [2:0]  vol_copies = fcl_pkg::RESET_FAT_COPIES;
	logic [15:0] vol_roots = fcl_pkg::RESET_ROOT_ENTRIES;
	logic [31:0] vol_total = '0;
	logic [3:0]  vol_slog = fcl_pkg::RESET_SECTOR_LOG2;
	logic [2:0]  vol_csl = '0;

	lookup_t   request_q[$];
	location_t located_q[$];

	logic        req_taken = 1'b0;
	bit          quiet = 1'b0;
	int unsigned src_gap = 0;
	int unsigned sink_gap = 0;
	int unsigned long_hold = 0;
	int unsigned cycles = 0;
	int unsigned errors = 0;
	int unsigned n_queued = 0;
	int unsigned n_taken = 0;
	int unsigned n_checked = 0;
	int unsigned n_settings = 0;

	fat_cluster_chain_locator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.cluster(cluster),
		.entry_word(entry_word),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.fat_kind(fat_kind),
		.table_sector(table_sector),
		.byte_offset(byte_offset),
		.next_link(next_link),
		.data_start(data_start)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic volume_t derive_volume();
		volume_t v;
		logic [31:0] bps;
		if (vol_slog < 4'd9) begin
			v.slog = 4'd9;
		end else if (vol_slog > 4'd12) begin
			v.slog = 4'd12;
		end else begin
			v.slog = vol_slog;
		end
		bps = 32'd1 << v.slog;
		v.root_secs = ({16'd0, vol_roots} * 32'd32 + bps - 32'd1) >> v.slog;
		v.data_base = {16'd0, vol_reserved} + vol_spf * {29'd0, vol_copies};
		// small volumes wrap and land in the largest type
		v.clusters = (vol_total - (v.data_base + v.root_secs)) >> vol_csl;
		return v;
	endfunction

	function automatic location_t locate_entry(input logic [27:0] cl, input logic [31:0] word);
		location_t r;
		volume_t v;
		logic [31:0] cl32, off, nxt, mask;
		v = derive_volume();
		cl32 = {4'd0, cl};
		if (v.clusters < fcl_pkg::FAT12_COUNT_LIMIT) begin
			r.kind = fcl_pkg::KIND_FAT12;
		end else if (v.clusters < fcl_pkg::FAT16_COUNT_LIMIT) begin
			r.kind = fcl_pkg::KIND_FAT16;
		end else begin
			r.kind = fcl_pkg::KIND_FAT32;
		end
		case (r.kind)
			fcl_pkg::KIND_FAT12: begin
				off = cl32 + (cl32 >> 1);
				nxt = cl32[0] ? {20'd0, word[15:4]} : {20'd0, word[11:0]};
				if (nxt >= {20'd0, fcl_pkg::FAT12_BAD}) nxt = '0;
			end
			fcl_pkg::KIND_FAT16: begin
				off = cl32 << 1;
				nxt = {16'd0, word[15:0]};
				if (nxt >= {16'd0, fcl_pkg::FAT16_BAD}) nxt = '0;
			end
			default: begin
				off = cl32 << 2;
				nxt = word & fcl_pkg::FAT32_MASK;
				if (nxt >= {4'd0, fcl_pkg::FAT32_BAD}) nxt = '0;
			end
		endcase
		mask = (32'd1 << v.slog) - 32'd1;
		r.sector = {16'd0, vol_reserved} + (off >> v.slog);
		r.offset = off[11:0] & mask[11:0];
		r.next = nxt[27:0];
		r.start = ((cl32 - 32'd2) << vol_csl) + v.data_base;
		// cluster 2 marks the root directory on FAT12/16
		if (cl32 > 32'd2 && r.kind != fcl_pkg::KIND_FAT32) r.start = r.start + v.root_secs;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= REPORT_LIMIT) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		end
	endtask

	// sender: present queued lookups, hold each word until taken
	always @(negedge clk) begin
		lookup_t item;
		if (req_valid && !req_taken) begin
			req_valid <= 1'b1;
		end else if (src_gap != 0) begin
			req_valid <= 1'b0;
			src_gap--;
		end else if (request_q.size() != 0) begin
			item = request_q.pop_front();
			req_valid <= 1'b1;
			cluster <= item.cl;
			entry_word <= item.word;
			if (!quiet && $urandom_range(0, 4) == 0) src_gap = $urandom_range(1, 3);
		end else begin
			req_valid <= 1'b0;
		end
	end

	// receiver: random stall bursts plus one long hold-off
	always @(negedge clk) begin
		if (long_hold != 0) begin
			rsp_ready <= 1'b0;
			long_hold--;
		end else if (sink_gap != 0) begin
			rsp_ready <= 1'b0;
			sink_gap--;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			rsp_ready <= 1'b0;
			sink_gap = $urandom_range(0, 2);
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		location_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			req_taken <= arst_n && req_valid && req_ready;
			if (arst_n && req_valid && req_ready) begin
				located_q.push_back(locate_entry(cluster, entry_word));
				n_taken++;
			end
			if (arst_n && rsp_valid && rsp_ready) begin
				if (located_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected word, expected none, actual sector %0h",
						$time, table_sector);
				end else begin
					want = located_q.pop_front();
					check_field("fat_kind", {30'd0, want.kind}, {30'd0, fat_kind});
					check_field("table_sector", want.sector, table_sector);
					check_field("byte_offset", {20'd0, want.offset}, {20'd0, byte_offset});
					check_field("next_link", {4'd0, want.next}, {4'd0, next_link});
					check_field("data_start", want.start, data_start);
					n_checked++;
				end
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			fcl_pkg::REG_RESERVED_SECTORS:     vol_reserved = val[15:0];
			fcl_pkg::REG_SECTORS_PER_FAT:      vol_spf = val;
			fcl_pkg::REG_FAT_COPIES:           vol_copies = val[2:0];
			fcl_pkg::REG_ROOT_ENTRIES:         vol_roots = val[15:0];
			fcl_pkg::REG_TOTAL_SECTORS:        vol_total = val;
			fcl_pkg::REG_SECTOR_SIZE_LOG2:     vol_slog = val[3:0];
			fcl_pkg::REG_CLUSTER_SECTORS_LOG2: vol_csl = val[2:0];
			default: ;
		endcase
	endtask

	// narrow registers get junk above their width, which must be dropped
	task automatic program_fixed(input logic [15:0] rsv, input logic [31:0] spf,
			input logic [2:0] copies, input logic [15:0] roots, input logic [31:0] total,
			input logic [3:0] slog, input logic [2:0] csl);
		logic [31:0] junk;
		junk = $urandom;
		write_reg(fcl_pkg::REG_RESERVED_SECTORS, {junk[15:0], rsv});
		write_reg(fcl_pkg::REG_SECTORS_PER_FAT, spf);
		write_reg(fcl_pkg::REG_FAT_COPIES, {junk[28:0], copies});
		write_reg(fcl_pkg::REG_ROOT_ENTRIES, {junk[31:16], roots});
		write_reg(fcl_pkg::REG_TOTAL_SECTORS, total);
		write_reg(fcl_pkg::REG_SECTOR_SIZE_LOG2, {junk[27:0], slog});
		write_reg(fcl_pkg::REG_CLUSTER_SECTORS_LOG2, {junk[30:2], csl});
		n_settings++;
	endtask

	// random geometry sized so the cluster count lands in the target type
	task automatic program_volume(input fcl_pkg::fat_kind_t target, input bit at_limit);
		volume_t v;
		logic [31:0] cnt, spf, rem;
		logic [2:0] csl;
		csl = 3'($urandom);
		spf = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20000);
		program_fixed(16'($urandom), spf, 3'($urandom), 16'($urandom), vol_total,
			4'($urandom_range(0, 15)), csl);
		v = derive_volume();
		case (target)
			fcl_pkg::KIND_FAT12: cnt = at_limit ? 32'd4084 : $urandom_range(0, 4084);
			fcl_pkg::KIND_FAT16: begin
				if (at_limit) begin
					cnt = $urandom_range(0, 1) ? 32'd4085 : 32'd65524;
				end else begin
					cnt = $urandom_range(4085, 65524);
				end
			end
			default: cnt = at_limit ? 32'd65525 : $urandom_range(65525, 32'hFFFF_FFFF >> csl);
		endcase
		rem = $urandom & ((32'd1 << csl) - 32'd1);
		write_reg(fcl_pkg::REG_TOTAL_SECTORS, v.data_base + v.root_secs + (cnt << csl) + rem);
	endtask

	task automatic add_lookup(input logic [27:0] cl, input logic [31:0] word);
		lookup_t item;
		item.cl = cl;
		item.word = word;
		request_q.push_back(item);
		n_queued++;
	endtask

	task automatic add_random_lookup();
		volume_t v;
		logic [31:0] span, word;
		logic [27:0] cl;
		int unsigned pick;
		v = derive_volume();
		span = (v.clusters > 32'h0FFF_FFFD) ? 32'h0FFF_FFFF : v.clusters + 32'd2;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			cl = 28'($urandom_range(0, span));
		end else if (pick < 8) begin
			cl = 28'($urandom);
		end else begin
			cl = $urandom_range(0, 1) ? 28'($urandom_range(0, 3)) : 28'hFFF_FFFF;
		end
		word = $urandom;
		// bias toward the end-of-chain region of each table type
		case ($urandom_range(0, 4))
			0: word[15:0] = 16'hFFF0 | 16'($urandom_range(0, 15));
			1: word[15:4] = 12'hFF0 | 12'($urandom_range(0, 15));
			2: word[27:0] = 28'hFFF_FFF0 | 28'($urandom_range(0, 15));
			default: ;
		endcase
		add_lookup(cl, word);
	endtask

	task automatic drain();
		while (n_taken != n_queued || located_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		int unsigned phase;
		fcl_pkg::fat_kind_t target;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset geometry: the volume count wraps, so FAT32
		add_lookup(28'd0, 32'h0000_0000);
		add_lookup(28'd1, 32'hFFFF_FFFF);
		add_lookup(28'd2, 32'h0FFF_FFF6);
		add_lookup(28'd3, 32'h0FFF_FFF7);
		add_lookup(28'hFFF_FFFF, 32'hF000_0005);
		add_lookup(28'h800_0001, 32'h5555_AAAA);
		drain();

		// floppy-like FAT12, even and odd entries, end marks, straddling entry
		program_fixed(16'd1, 32'd9, 3'd2, 16'd224, 32'd2880, 4'd9, 3'd0);
		add_lookup(28'd2, 32'h0000_0003);
		add_lookup(28'd3, 32'h0000_FF60);
		add_lookup(28'd5, 32'h0000_FF70);
		add_lookup(28'd4, 32'hFFFF_0FF7);
		add_lookup(28'd4, 32'h0000_FFF6);
		add_lookup(28'd1, 32'h0000_FFFF);
		add_lookup(28'd0, 32'hABCD_1234);
		add_lookup(28'd341, 32'h1234_5678);
		drain();

		program_fixed(16'd4, 32'd256, 3'd2, 16'd512, 32'd160548, 4'd9, 3'd2);
		add_lookup(28'd2, 32'h0000_FFF6);
		add_lookup(28'd3, 32'h0000_FFF7);
		add_lookup(28'd65535, 32'hFFFF_0001);
		add_lookup(28'h1000, 32'h0000_8000);
		add_lookup(28'd256, 32'h1234_FFFE);
		drain();

		for (phase = 0; phase < 9; phase++) begin
			case (phase)
				3: program_fixed(16'hFFFF, 32'hFFFF_FFFF, 3'd7, 16'hFFFF, 32'hFFFF_FFFF,
					4'd15, 3'd7);
				6: program_fixed(16'd0, 32'd0, 3'd0, 16'd0, 32'd0, 4'd0, 3'd0);
				default: begin
					target = fcl_pkg::fat_kind_t'(phase % 3);
					program_volume(target, phase == 1 || phase == 5 || phase == 7);
				end
			endcase
			if (phase == 4) write_reg(REG_NONE, $urandom);
			// the receiver holds off while the sender keeps offering words
			if (phase == 2) long_hold = 48;
			if (phase == 8) quiet = 1'b1;
			repeat (55) add_random_lookup();
			drain();
		end

		repeat (12) @(posedge clk);
		$display("Checked %0d lookups over %0d volume settings: FAT12/16/32 at the type limits,",
			n_checked, n_settings);
		$display("clamped sector sizes, wrapped geometry, end-of-chain codes and root marker.");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### fat_cluster_chain_locator.f
src/fcl_pkg.sv
src/fat_cluster_chain_locator.sv
bench/tb_fat_cluster_chain_locator.sv
